[rtl/rwf_pkg.sv]
package rwf_pkg;

    // One tick of inputs
    typedef struct packed {
        logic podium_pressed;
        logic error_active;
        logic start_event;
        logic advance_waypoint;
    } t_in_item;

    // One tick of LED duty levels
    typedef struct packed {
        logic [7:0] red_duty;
        logic [7:0] green_duty;
        logic [7:0] blue_duty;
        logic [2:0] write_mask;
    } t_out_item;

    // On/off pattern of one waypoint, bit 2 red, bit 1 green, bit 0 blue
    typedef logic [2:0] t_rgb_on;

    // Configuration register indexes
    localparam logic [1:0] CFG_STEP_SIZE    = 2'd0;
    localparam logic [1:0] CFG_OUTPUT_SHIFT = 2'd1;
    localparam logic [1:0] CFG_FLASH_TICKS  = 2'd2;

    localparam logic [7:0] STEP_SIZE_RST    = 8'd8;
    localparam logic [2:0] OUTPUT_SHIFT_RST = 3'd0;
    localparam logic [4:0] FLASH_TICKS_RST  = 5'd30;

    // Write mask codes
    localparam logic [2:0] MASK_NONE = 3'b000;
    localparam logic [2:0] MASK_BLUE = 3'b100;
    localparam logic [2:0] MASK_ALL  = 3'b111;

    localparam logic [7:0] LEVEL_FULL = 8'hFF;
    localparam logic [7:0] LEVEL_OFF  = 8'h00;

    // Rainbow: red, yellow, green, blue-green, blue, purple, repeating
    function automatic t_rgb_on rainbow_on(input logic [3:0] k);
        t_rgb_on r;
        case (k)
            4'd0, 4'd6, 4'd12:  r = 3'b100;
            4'd1, 4'd7, 4'd13:  r = 3'b110;
            4'd2, 4'd8, 4'd14:  r = 3'b010;
            4'd3, 4'd9, 4'd15:  r = 3'b011;
            4'd4, 4'd10:        r = 3'b001;
            default:            r = 3'b101;
        endcase
        return r;
    endfunction

    // Blink: red, then off
    function automatic t_rgb_on blink_on(input logic k);
        return k ? 3'b000 : 3'b100;
    endfunction

endpackage

[rtl/rgb_waypoint_fader.sv]
// rgb_waypoint_fader: three-channel LED fader, one input item per tick and
// exactly one result item per input item. Priority per tick: podium press
// (full blue, loads the flash countdown), countdown running (blue ramps up,
// only blue written), error mode (fade along red/off blink), waiting for
// start (nothing written, mask 0), rainbow mode (fade along RAINBOW_POINTS
// waypoints). A start_event takes effect in its own tick. Each faded channel
// moves by step_size toward the next waypoint and stops there; an advance
// jumps levels and index to that waypoint after the output. Levels leave
// shifted right by output_shift. Timing: an item waits in the input
// register, its fade update runs between that register and the result
// register, and a new item is accepted every cycle (one item per clock
// sustained) unless the output stalls; state is updated as an item moves
// into the result register. Configuration writes take effect at the next
// edge; the user must make them only while the block is idle, the block does not enforce this.
module rgb_waypoint_fader #(
    parameter int RAINBOW_POINTS = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rwf_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rwf_pkg::t_out_item  o_out,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [7:0]          i_cfg_data
);
    import rwf_pkg::*;

    localparam int IW = $clog2(RAINBOW_POINTS);

    // configuration
    logic [7:0] r_step_size;
    logic [2:0] r_output_shift;
    logic [4:0] r_flash_ticks;

    // pipeline
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    // fader state
    logic [7:0]    r_level [3];
    logic [7:0]    n_level [3];
    logic [IW-1:0] r_idx;
    logic [IW-1:0] n_idx;
    logic [4:0]    r_flash;
    logic [4:0]    n_flash;
    logic          r_started;

    logic out_take;   // result register can load this cycle
    logic xfer;       // item moves from input to result register

    assign out_take    = !r_out_valid || i_out_ready;
    assign xfer        = r_in_valid && out_take;
    assign o_in_ready  = !r_in_valid || out_take;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // configuration port; index 3 is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size    <= STEP_SIZE_RST;
            r_output_shift <= OUTPUT_SHIFT_RST;
            r_flash_ticks  <= FLASH_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STEP_SIZE:    r_step_size    <= i_cfg_data;
                CFG_OUTPUT_SHIFT: r_output_shift <= i_cfg_data[2:0];
                CFG_FLASH_TICKS:  r_flash_ticks  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // waypoint selection; the stored index always lies inside the rainbow
    // table, and the blink table only looks at its low bit
    logic [IW-1:0] cur_idx;
    logic [IW:0]   cur_inc;
    logic [IW-1:0] nxt_idx;
    t_rgb_on       on_a;
    t_rgb_on       on_b;
    logic          started_now;
    logic          fade_mode;

    always_comb begin
        started_now = r_started || r_in.start_event;
        fade_mode   = r_in.error_active || started_now;
        if (r_in.error_active) begin
            cur_idx = IW'(r_idx[0]);
            cur_inc = '0;
            nxt_idx = IW'(!r_idx[0]);
            on_a    = blink_on(r_idx[0]);
            on_b    = blink_on(!r_idx[0]);
        end else begin
            cur_idx = r_idx;
            cur_inc = {1'b0, r_idx} + (IW+1)'(1);
            nxt_idx = (cur_inc == (IW+1)'(RAINBOW_POINTS)) ? '0 : cur_inc[IW-1:0];
            on_a    = rainbow_on(4'(cur_idx));
            on_b    = rainbow_on(4'(nxt_idx));
        end
    end

    // per-channel fade: every waypoint channel is full or off, so the
    // distance is 255 and the step works out to step_size itself
    logic [7:0] faded [3];
    logic [8:0] sum   [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch]   = {1'b0, r_level[ch]} + {1'b0, r_step_size};
            faded[ch] = r_level[ch];
            if (on_a[2-ch] != on_b[2-ch] && r_step_size != 8'd0) begin
                if (on_b[2-ch]) begin
                    faded[ch] = sum[ch][8] ? LEVEL_FULL : sum[ch][7:0];
                end else begin
                    faded[ch] = (r_level[ch] >= r_step_size) ?
                                (r_level[ch] - r_step_size) : LEVEL_OFF;
                end
            end
        end
    end

    // next state and result
    always_comb begin
        n_out   = '0;
        n_level = r_level;
        n_idx   = r_idx;
        n_flash = r_flash;
        if (r_in.podium_pressed) begin
            n_flash          = r_flash_ticks;
            n_out.blue_duty  = LEVEL_FULL;
            n_out.write_mask = MASK_ALL;
        end else if (r_flash != 5'd0) begin
            n_flash          = r_flash - 5'd1;
            n_out.blue_duty  = LEVEL_FULL - {n_flash, 3'b000};
            n_out.write_mask = MASK_BLUE;
        end else if (fade_mode) begin
            n_level          = faded;
            n_out.red_duty   = faded[0] >> r_output_shift;
            n_out.green_duty = faded[1] >> r_output_shift;
            n_out.blue_duty  = faded[2] >> r_output_shift;
            n_out.write_mask = MASK_ALL;
            if (r_in.advance_waypoint) begin
                for (int ch = 0; ch < 3; ch++) begin
                    n_level[ch] = on_b[2-ch] ? LEVEL_FULL : LEVEL_OFF;
                end
                n_idx = nxt_idx;
            end
        end else begin
            n_out.write_mask = MASK_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_level[0]  <= LEVEL_FULL;
            r_level[1]  <= LEVEL_OFF;
            r_level[2]  <= LEVEL_OFF;
            r_idx       <= '0;
            r_flash     <= '0;
            r_started   <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_take) begin
                r_out_valid <= r_in_valid;
            end
            if (xfer) begin
                r_level   <= n_level;
                r_idx     <= n_idx;
                r_flash   <= n_flash;
                r_started <= started_now;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (xfer) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_idx) < RAINBOW_POINTS)
        else $error("waypoint index outside rainbow table");

    a_press_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && r_in.podium_pressed |=> r_flash == $past(r_flash_ticks))
        else $error("press did not load flash countdown");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.write_mask == MASK_NONE |->
        r_out.red_duty == 8'd0 && r_out.green_duty == 8'd0 && r_out.blue_duty == 8'd0)
        else $error("nonzero duty with nothing written");

    a_count_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && !r_in.podium_pressed && r_flash != 5'd0 |=>
        r_out.write_mask == MASK_BLUE && r_level[0] == $past(r_level[0]) &&
        r_level[1] == $past(r_level[1]) && r_level[2] == $past(r_level[2]))
        else $error("countdown tick touched levels or mask");
`endif

endmodule
